// ===== design/losro_pkg.sv =====
// ----------------------------------------------------------------------------
// losro_pkg
// Shared types for the rectangle occlusion line-of-sight block.
// ----------------------------------------------------------------------------
package losro_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MU_HOLD,
      MU_MUL,
      MU_MOV,
      MU_ADD
   } mu_op_type;

   typedef struct packed {
      logic      en;
      mu_op_type op;
   } mu_ctl_type;

endpackage

// ===== design/losro_mulcmp.sv =====
// ----------------------------------------------------------------------------
// losro_mulcmp
// Shared multiply, accumulate and compare unit: one signed product per cycle
// while enabled, registered, and the sign of accumulator minus product.
// ----------------------------------------------------------------------------
module losro_mulcmp
   import losro_pkg::*;
#(
   parameter int W = 17
) (
   input  logic                clock,
   input  mu_ctl_type          ctl,
   input  logic signed [W-1:0] op_a,
   input  logic signed [W-1:0] op_b,
   output logic                gt
);

   logic signed [2*W-1:0] prod_ff;
   logic signed [2*W:0]   acc_ff;
   logic signed [2*W:0]   prod_ext;
   logic signed [2*W:0]   diff;

   assign prod_ext = {prod_ff[2*W-1], prod_ff};
   assign diff     = acc_ff - prod_ext;
   assign gt       = !diff[2*W] && (diff != '0);

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         case (ctl.op)
            MU_MUL: begin
               prod_ff <= op_a * op_b;
            end
            MU_MOV: begin
               acc_ff  <= prod_ext;
               prod_ff <= op_a * op_b;
            end
            MU_ADD: begin
               acc_ff  <= acc_ff + prod_ext;
               prod_ff <= op_a * op_b;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== design/line_of_sight_rect_occlusion.sv =====
// ----------------------------------------------------------------------------
// line_of_sight_rect_occlusion
// Occluder rectangle table with segment-versus-rectangle visibility queries.
// ----------------------------------------------------------------------------
// Clear and append finish in their accept cycle. A query runs the range
// check (states DST0 to DST3), then, for every stored rectangle, a table
// read and two slab axes, each with three exact fraction compares on the
// single shared multiplier, stopping early on the first blocker. A closing
// state follows, held while an earlier result is still waiting. New
// requests stall until the block is idle again. All multiplies go through
// that one multiplier, which sets the rate. Results appear only for a query
// marked last_eye, held in an output register until taken.
module line_of_sight_rect_occlusion
   import losro_pkg::*;
#(
   parameter int MAX_RECTS  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_command,
   input  logic signed [COORD_BITS-1:0] req_rect_min_x,
   input  logic signed [COORD_BITS-1:0] req_rect_min_z,
   input  logic signed [COORD_BITS-1:0] req_rect_max_x,
   input  logic signed [COORD_BITS-1:0] req_rect_max_z,
   input  logic signed [COORD_BITS-1:0] req_viewer_x,
   input  logic signed [COORD_BITS-1:0] req_viewer_z,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic [COORD_BITS-1:0]        req_eye_range,
   input  logic                         req_last_eye,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_visible,
   output logic                         rsp_table_overflowed
);

   localparam int CW = COORD_BITS;
   localparam int W  = CW + 1;
   localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int NW = $clog2(MAX_RECTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DST0, ST_DST1, ST_DST2, ST_DST3, ST_RD, ST_LD,
      ST_AX, ST_M0, ST_M1, ST_M2, ST_NX, ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      FR_ENTRY, FR_EXIT, FR_EMPTY
   } frac_type;

   logic [4*CW-1:0] mem [MAX_RECTS];
   logic [4*CW-1:0] rd_ff;

   state_type       state_ff;
   frac_type        k_ff;
   logic [NW-1:0]   count_ff;
   logic [IW-1:0]   idx_ff;
   logic            axis_ff;
   logic            seen_ff;
   logic            sees_ff;
   logic            overflow_ff;
   logic            last_ff;
   logic            rsp_valid_ff;
   logic            rsp_visible_ff;
   logic            rsp_ovf_ff;

   logic signed [W-1:0] vx_ff, vz_ff, dx_ff, dz_ff, range_ff;
   logic signed [W-1:0] n0_ff, n1_ff, den_ff;
   logic signed [W-1:0] t0n_ff, t0d_ff, t1n_ff, t1d_ff;

   logic signed [W-1:0] ax_lo, ax_hi, ax_den, ax_n0, ax_n1, ax_v;
   logic signed [W-1:0] mu_a, mu_b;
   logic                mu_gt;
   mu_ctl_type          mu_ctl;
   logic                accept;
   logic                rsp_free;

   assign req_stall            = (state_ff != ST_IDLE);
   assign accept               = req_valid && !req_stall;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_visible          = rsp_visible_ff;
   assign rsp_table_overflowed = rsp_ovf_ff;
   assign rsp_free             = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (accept && (req_command == CMD_APPEND) && (count_ff < NW'(MAX_RECTS))) begin
         mem[count_ff[IW-1:0]] <= {req_rect_max_z, req_rect_max_x,
                                   req_rect_min_z, req_rect_min_x};
      end
      rd_ff <= mem[idx_ff];
   end

   // slab setup for the current axis
   always_comb begin
      logic signed [CW-1:0] cmin, cmax;
      logic signed [W-1:0]  a0, a1;
      if (axis_ff) begin
         cmin = rd_ff[2*CW-1:CW];
         cmax = rd_ff[4*CW-1:3*CW];
         ax_v = vz_ff;
         ax_den = dz_ff;
      end else begin
         cmin = rd_ff[CW-1:0];
         cmax = rd_ff[3*CW-1:2*CW];
         ax_v = vx_ff;
         ax_den = dx_ff;
      end
      ax_lo = {cmin[CW-1], cmin} - ax_v;
      ax_hi = {cmax[CW-1], cmax} - ax_v;
      if (ax_den < 0) begin
         a0 = -ax_lo;
         a1 = -ax_hi;
      end else begin
         a0 = ax_lo;
         a1 = ax_hi;
      end
      if (a0 > a1) begin
         ax_n0 = a1;
         ax_n1 = a0;
      end else begin
         ax_n0 = a0;
         ax_n1 = a1;
      end
   end

   // operand selection for the shared unit
   always_comb begin
      mu_ctl.en = 1'b1;
      mu_ctl.op = MU_HOLD;
      mu_a      = '0;
      mu_b      = '0;
      case (state_ff)
         ST_DST0: begin
            mu_ctl.op = MU_MUL;
            mu_a = dx_ff;
            mu_b = dx_ff;
         end
         ST_DST1: begin
            mu_ctl.op = MU_MOV;
            mu_a = dz_ff;
            mu_b = dz_ff;
         end
         ST_DST2: begin
            mu_ctl.op = MU_ADD;
            mu_a = range_ff;
            mu_b = range_ff;
         end
         ST_M0: begin
            mu_ctl.op = MU_MUL;
            case (k_ff)
               FR_ENTRY: begin mu_a = n0_ff;  mu_b = t0d_ff; end
               FR_EXIT:  begin mu_a = t1n_ff; mu_b = den_ff; end
               default:  begin mu_a = t0n_ff; mu_b = t1d_ff; end
            endcase
         end
         ST_M1: begin
            mu_ctl.op = MU_MOV;
            case (k_ff)
               FR_ENTRY: begin mu_a = t0n_ff; mu_b = den_ff; end
               FR_EXIT:  begin mu_a = n1_ff;  mu_b = t1d_ff; end
               default:  begin mu_a = t1n_ff; mu_b = t0d_ff; end
            endcase
         end
         default: begin
            mu_ctl.en = 1'b0;
         end
      endcase
   end

   losro_mulcmp #(.W(W)) u_mulcmp (
      .clock (clock),
      .ctl   (mu_ctl),
      .op_a  (mu_a),
      .op_b  (mu_b),
      .gt    (mu_gt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         axis_ff      <= 1'b0;
         k_ff         <= FR_ENTRY;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !((state_ff == ST_FIN) && last_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_command)
                     CMD_CLEAR: begin
                        count_ff <= '0;
                     end
                     CMD_APPEND: begin
                        if (count_ff < NW'(MAX_RECTS)) begin
                           count_ff <= count_ff + 1'b1;
                        end else begin
                           overflow_ff <= 1'b1;
                        end
                     end
                     CMD_QUERY: begin
                        vx_ff    <= {req_viewer_x[CW-1], req_viewer_x};
                        vz_ff    <= {req_viewer_z[CW-1], req_viewer_z};
                        dx_ff    <= {req_point_x[CW-1], req_point_x}
                                    - {req_viewer_x[CW-1], req_viewer_x};
                        dz_ff    <= {req_point_z[CW-1], req_point_z}
                                    - {req_viewer_z[CW-1], req_viewer_z};
                        range_ff <= {1'b0, req_eye_range};
                        last_ff  <= req_last_eye;
                        state_ff <= ST_DST0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_DST0: state_ff <= ST_DST1;
            ST_DST1: state_ff <= ST_DST2;
            ST_DST2: state_ff <= ST_DST3;
            ST_DST3: begin
               idx_ff <= '0;
               if (mu_gt) begin
                  sees_ff  <= 1'b0;
                  state_ff <= ST_FIN;
               end else begin
                  sees_ff  <= 1'b1;
                  state_ff <= (count_ff == '0) ? ST_FIN : ST_RD;
               end
            end
            ST_RD: state_ff <= ST_LD;
            ST_LD: begin
               axis_ff  <= 1'b0;
               t0n_ff   <= '0;
               t0d_ff   <= W'(1);
               t1n_ff   <= W'(1);
               t1d_ff   <= W'(1);
               state_ff <= ST_AX;
            end
            ST_AX: begin
               if (ax_den == '0) begin
                  if ((ax_lo > 0) || (ax_hi < 0)) begin
                     state_ff <= ST_NX;
                  end else if (axis_ff) begin
                     sees_ff  <= 1'b0;
                     state_ff <= ST_FIN;
                  end else begin
                     axis_ff <= 1'b1;
                  end
               end else begin
                  n0_ff    <= ax_n0;
                  n1_ff    <= ax_n1;
                  den_ff   <= (ax_den < 0) ? -ax_den : ax_den;
                  k_ff     <= FR_ENTRY;
                  state_ff <= ST_M0;
               end
            end
            ST_M0: state_ff <= ST_M1;
            ST_M1: state_ff <= ST_M2;
            ST_M2: begin
               case (k_ff)
                  FR_ENTRY: begin
                     if (mu_gt) begin
                        t0n_ff <= n0_ff;
                        t0d_ff <= den_ff;
                     end
                     k_ff     <= FR_EXIT;
                     state_ff <= ST_M0;
                  end
                  FR_EXIT: begin
                     if (mu_gt) begin
                        t1n_ff <= n1_ff;
                        t1d_ff <= den_ff;
                     end
                     k_ff     <= FR_EMPTY;
                     state_ff <= ST_M0;
                  end
                  default: begin
                     if (mu_gt) begin
                        state_ff <= ST_NX;
                     end else if (axis_ff) begin
                        sees_ff  <= 1'b0;
                        state_ff <= ST_FIN;
                     end else begin
                        axis_ff  <= 1'b1;
                        state_ff <= ST_AX;
                     end
                  end
               endcase
            end
            ST_NX: begin
               if (NW'(idx_ff) + 1'b1 >= count_ff) begin
                  state_ff <= ST_FIN;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_FIN: begin
               if (!last_ff) begin
                  seen_ff  <= seen_ff || sees_ff;
                  state_ff <= ST_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_visible_ff <= seen_ff || sees_ff;
                  rsp_ovf_ff     <= overflow_ff;
                  seen_ff        <= 1'b0;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_RECTS))
      else $error("rectangle count above table size");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_QUERY)) |=> (state_ff == ST_DST0))
      else $error("query transaction did not start the range check");

   a_denoms_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_M0 || state_ff == ST_M1 || state_ff == ST_M2)
      |-> (t0d_ff > 0 && t1d_ff > 0 && den_ff > 0))
      else $error("fraction denominator not positive");

endmodule
